>>> rtl/go_back_n_sender_window_assert.svh
// -----------------------------------------------------------------------------
// Go-Back-N sender window - assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GBN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gbn_pkg.sv
// -----------------------------------------------------------------------------
// Go-Back-N sender window - shared package
// Transaction payload types, request and result codes, control structs.
// -----------------------------------------------------------------------------
package gbn_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_ACK   = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_RETX = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 2'd3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [5:0] WINDOW_SIZE_RST   = 6'd8;
    localparam logic [3:0] DUP_THRESHOLD_RST = 4'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ack_number;
        logic        ack_good;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [15:0] packet_index;
        logic [31:0] wire_seq;
        logic [15:0] window_base;
        logic [15:0] window_next;
        logic        transfer_done;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic exec;   // process the accepted input transaction
        logic emit;   // issue the next retransmission of the run
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic run_req;   // presented item starts a retransmission run
        logic run_last;  // next retransmission is the final one
    } t_stat;

endpackage

>>> rtl/go_back_n_sender_window.sv
// -----------------------------------------------------------------------------
// Go-Back-N sender window with fast retransmit - top level
// Timing: ack and admitted send results are registered; a replay first enters the run state.
// Throughput: one send or ack per cycle if the output is free; a replay holds input off.
// Reset: synchronous active-low i_rst_n restores register defaults and window state.
// -----------------------------------------------------------------------------
module go_back_n_sender_window #(
    parameter int WINDOW_MAX = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gbn_pkg::t_in_item              i_in_item,
    // result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gbn_pkg::t_out_item             o_out_item,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gbn_pkg::t_cmd  cmd;
    gbn_pkg::t_stat stat;

    // sequencer
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // window state and result stage
    gbn_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/gbn_ctrl.sv
// -----------------------------------------------------------------------------
// Go-Back-N sender window - controller
// Two-state sequencer: takes input transactions when idle and steps the
// datapath through a retransmission run one result per cycle while the output is free.
// -----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  gbn_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output gbn_pkg::t_cmd  o_cmd
);

    gbn_pkg::t_state r_state;
    gbn_pkg::t_state n_state;
    logic            accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        accept     = 1'b0;
        case (r_state)
            gbn_pkg::S_IDLE: begin
                o_in_ready = i_stat.out_free;
                accept     = i_in_valid && i_stat.out_free;
                o_cmd.exec = accept;
                if (accept && i_stat.run_req) begin
                    n_state = gbn_pkg::S_RUN;
                end
            end
            gbn_pkg::S_RUN: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.run_last) begin
                    n_state = gbn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::S_IDLE;
            end
        endcase
    end

    `include "go_back_n_sender_window_assert.svh"

    `GBN_ASSERT_NOW(a_run_blocks_input, r_state == gbn_pkg::S_RUN, !o_in_ready, "input taken during run")
    `GBN_ASSERT_NEXT(a_run_entered, accept && i_stat.run_req, r_state == gbn_pkg::S_RUN, "run not started")
    `GBN_ASSERT_NOW(a_cmd_exclusive, o_cmd.exec, !o_cmd.emit, "exec and emit together")

endmodule

>>> rtl/gbn_dpath.sv
// -----------------------------------------------------------------------------
// Go-Back-N sender window - datapath
// Configuration and window state registers, ack and send evaluation,
// retransmission run counter and the registered result stage.
// -----------------------------------------------------------------------------
module gbn_dpath #(
    parameter int WINDOW_MAX = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gbn_pkg::t_in_item                   i_in_item,
    input  logic                                i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_ready,
    input  gbn_pkg::t_cmd                       i_cmd,
    output gbn_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    output gbn_pkg::t_out_item                  o_out_item
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [6:0]  WIN_CAP = 7'(WINDOW_MAX);
    localparam logic [32:0] RUN_CAP = 33'(WINDOW_MAX);

    // configuration
    logic [5:0]            r_window_size,   n_window_size;
    logic [15:0]           r_message_count, n_message_count;
    logic [31:0]           r_seq_offset,    n_seq_offset;
    logic [3:0]            r_dup_threshold, n_dup_threshold;
    // window state
    logic [INDEX_BITS-1:0] r_base, n_base;
    logic [INDEX_BITS-1:0] r_next, n_next;
    logic                  r_pending, n_pending;
    logic                  r_done, n_done;
    logic [31:0]           r_prev_ack, n_prev_ack;
    logic [3:0]            r_dup_count, n_dup_count;
    // retransmission run
    logic [INDEX_BITS-1:0] r_ridx, n_ridx;
    logic [CW-1:0]         r_left, n_left;
    // result stage
    logic                  r_out_valid, n_out_valid;
    gbn_pkg::t_out_item    r_out_item, n_out_item;

    logic [6:0]            win;
    logic                  admit;
    logic [31:0]           rel;
    logic [32:0]           rel_inc;
    logic [INDEX_BITS-1:0] run_span;
    logic [CW-1:0]         run_cnt;
    logic [3:0]            dup_inc;
    logic                  load;
    logic [1:0]            res_kind;
    logic [INDEX_BITS-1:0] res_idx;
    logic                  res_last;
    logic                  ack_exec;

    // shared evaluation terms
    assign win      = (7'(r_window_size) > WIN_CAP) ? WIN_CAP : 7'(r_window_size);
    assign admit    = (33'(r_next) < 33'(r_base) + 33'(win))
                   && (33'(r_next) <= 33'(r_message_count) + 33'd1)
                   && (r_next != IDX_MAX);
    assign rel      = i_in_item.ack_number - r_seq_offset;
    assign rel_inc  = 33'(rel) + 33'd1;
    assign run_span = r_next - r_base;
    assign run_cnt  = (33'(run_span) > RUN_CAP) ? CW'(WINDOW_MAX) : CW'(run_span);
    assign dup_inc  = (r_dup_count == 4'hF) ? 4'hF : r_dup_count + 4'd1;
    assign ack_exec = i_cmd.exec && (i_in_item.req_type == gbn_pkg::REQ_ACK);

    // status to controller
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.run_req  = (i_in_item.req_type == gbn_pkg::REQ_SEND) && !r_done
                          && r_pending && (r_next > r_base);
    assign o_stat.run_last = (r_left == CW'(1));

    // next state
    always_comb begin
        n_window_size   = r_window_size;
        n_message_count = r_message_count;
        n_seq_offset    = r_seq_offset;
        n_dup_threshold = r_dup_threshold;
        n_base          = r_base;
        n_next          = r_next;
        n_pending       = r_pending;
        n_done          = r_done;
        n_prev_ack      = r_prev_ack;
        n_dup_count     = r_dup_count;
        n_ridx          = r_ridx;
        n_left          = r_left;
        load            = 1'b0;
        res_kind        = gbn_pkg::KIND_ACK;
        res_idx         = '0;
        res_last        = 1'b1;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                gbn_pkg::CFG_WINDOW_SIZE:   n_window_size   = i_cfg_data[5:0];
                gbn_pkg::CFG_MESSAGE_COUNT: n_message_count = i_cfg_data[15:0];
                gbn_pkg::CFG_SEQ_OFFSET:    n_seq_offset    = i_cfg_data;
                gbn_pkg::CFG_DUP_THRESHOLD: n_dup_threshold = i_cfg_data[3:0];
                default: ;
            endcase
        end

        // input transaction
        if (i_cmd.exec) begin
            case (i_in_item.req_type)
                gbn_pkg::REQ_SEND: begin
                    if (!r_done) begin
                        if (r_pending) begin
                            // arm the replay of base..next-1
                            n_pending = 1'b0;
                            n_ridx    = r_base;
                            n_left    = (r_next > r_base) ? run_cnt : '0;
                        end else if (admit) begin
                            n_next   = r_next + INDEX_BITS'(1);
                            load     = 1'b1;
                            res_kind = gbn_pkg::KIND_NEW;
                            res_idx  = r_next;
                        end
                    end
                end
                gbn_pkg::REQ_ACK: begin
                    load = 1'b1;
                    if (i_in_item.ack_good && !r_done) begin
                        // cumulative advance, saturated at the top index
                        if (rel >= 32'(r_base)) begin
                            n_base = (rel_inc > 33'(IDX_MAX)) ? IDX_MAX
                                                              : rel_inc[INDEX_BITS-1:0];
                        end
                        if (rel == 32'(r_message_count) + 32'd1) begin
                            n_done = 1'b1;
                        end else if (r_prev_ack != i_in_item.ack_number) begin
                            n_prev_ack  = i_in_item.ack_number;
                            n_dup_count = '0;
                        end else if (dup_inc >= r_dup_threshold) begin
                            n_pending   = 1'b1;
                            n_dup_count = '0;
                        end else begin
                            n_dup_count = dup_inc;
                        end
                    end
                end
                gbn_pkg::REQ_RESET: begin
                    n_base          = INDEX_BITS'(1);
                    n_next          = INDEX_BITS'(1);
                    n_pending       = 1'b0;
                    n_done          = 1'b0;
                    n_prev_ack      = '0;
                    n_dup_count     = '0;
                    n_message_count = '0;
                    n_seq_offset    = '0;
                end
                default: ;
            endcase
        end

        // retransmission step
        if (i_cmd.emit) begin
            load     = 1'b1;
            res_kind = gbn_pkg::KIND_RETX;
            res_idx  = r_ridx;
            res_last = (r_left == CW'(1));
            n_ridx   = r_ridx + INDEX_BITS'(1);
            n_left   = r_left - CW'(1);
        end
    end

    // result assembly; window fields show the state after the step
    always_comb begin
        n_out_item = r_out_item;
        if (load) begin
            n_out_item.out_kind      = res_kind;
            n_out_item.packet_index  = 16'(res_idx);
            n_out_item.wire_seq      = (res_kind == gbn_pkg::KIND_ACK) ? 32'd0
                                     : r_seq_offset + 32'(res_idx);
            n_out_item.window_base   = 16'(n_base);
            n_out_item.window_next   = 16'(n_next);
            n_out_item.transfer_done = n_done;
            n_out_item.last_of_run   = res_last;
        end
        n_out_valid = load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= gbn_pkg::WINDOW_SIZE_RST;
            r_message_count <= '0;
            r_seq_offset    <= '0;
            r_dup_threshold <= gbn_pkg::DUP_THRESHOLD_RST;
            r_base          <= INDEX_BITS'(1);
            r_next          <= INDEX_BITS'(1);
            r_pending       <= 1'b0;
            r_done          <= 1'b0;
            r_prev_ack      <= '0;
            r_dup_count     <= '0;
            r_left          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_window_size   <= n_window_size;
            r_message_count <= n_message_count;
            r_seq_offset    <= n_seq_offset;
            r_dup_threshold <= n_dup_threshold;
            r_base          <= n_base;
            r_next          <= n_next;
            r_pending       <= n_pending;
            r_done          <= n_done;
            r_prev_ack      <= n_prev_ack;
            r_dup_count     <= n_dup_count;
            r_left          <= n_left;
            r_out_valid     <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ridx     <= n_ridx;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `include "go_back_n_sender_window_assert.svh"

    `GBN_ASSERT_NOW(a_emit_has_work, i_cmd.emit, r_left != '0, "emit with empty run")
    `GBN_ASSERT_NOW(a_run_in_window, r_left != '0, 33'(r_next) >= 33'(r_base) + 33'(r_left), "run overrun")
    `GBN_ASSERT_NOW(a_done_by_ack, $rose(r_done), $past(ack_exec), "done set without ack")

endmodule
